>>> src/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// shared constants and types of the segment intersection block
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int COORD_FRAC_BITS = 12;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int TOL_WIDTH       = 16;
  localparam int TOL_FRAC_BITS   = 16;
  localparam int KIND_WIDTH      = 2;

  localparam logic [KIND_WIDTH-1:0] KIND_NONE    = 2'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_POINT   = 2'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_OVERLAP = 2'd2;

  typedef struct packed {
    logic hi;
    logic lo;
  } div_sat_t;

endpackage

`default_nettype wire

>>> src/ssi_if.sv
// ----------------------------------------------------------------------------
// ssi interfaces
// request, result and configuration channels of the segment intersection block
// ----------------------------------------------------------------------------
`default_nettype none

interface ssi_seg_if #(
  parameter int CoordWidth = ssi_pkg::COORD_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] seg_a_start_x;
  logic signed [CoordWidth-1:0] seg_a_start_y;
  logic signed [CoordWidth-1:0] seg_a_end_x;
  logic signed [CoordWidth-1:0] seg_a_end_y;
  logic signed [CoordWidth-1:0] seg_b_start_x;
  logic signed [CoordWidth-1:0] seg_b_start_y;
  logic signed [CoordWidth-1:0] seg_b_end_x;
  logic signed [CoordWidth-1:0] seg_b_end_y;

  modport source (output valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                  seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y, input ready);
  modport sink (input valid, seg_a_start_x, seg_a_start_y, seg_a_end_x, seg_a_end_y,
                seg_b_start_x, seg_b_start_y, seg_b_end_x, seg_b_end_y, output ready);
endinterface

interface ssi_res_if #(
  parameter int CoordWidth = ssi_pkg::COORD_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic [ssi_pkg::KIND_WIDTH-1:0]    kind;
  logic signed [CoordWidth-1:0]      point_x;
  logic signed [CoordWidth-1:0]      point_y;

  modport source (output valid, kind, point_x, point_y, input ready);
  modport sink (input valid, kind, point_x, point_y, output ready);
endinterface

interface ssi_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ssi_pkg::TOL_WIDTH-1:0] tolerance;

  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface

`default_nettype wire

>>> src/ssi_div.sv
// ----------------------------------------------------------------------------
// ssi_div
// pipelined restoring divider, one quotient bit per stage, saturating result
// ----------------------------------------------------------------------------
`default_nettype none

module ssi_div #(
  parameter int DEN_WIDTH       = 51,
  parameter int PARAM_FRAC_BITS = ssi_pkg::PARAM_FRAC_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [DEN_WIDTH+2:0]                num_i,
  input  wire logic [DEN_WIDTH-1:0]                den_i,
  input  wire ssi_pkg::div_sat_t                   sat_i,
  output logic signed [PARAM_FRAC_BITS+3:0]        quo_o
);

  localparam int RW = DEN_WIDTH + 3;
  localparam int NQ = PARAM_FRAC_BITS + 3;
  localparam int QW = PARAM_FRAC_BITS + 4;
  localparam logic signed [QW-1:0] FOUR = QW'(4) << PARAM_FRAC_BITS;

  logic [RW-1:0]      r_q   [NQ];
  logic [RW-1:0]      d4_q  [NQ];
  logic [NQ-1:0]      q_q   [NQ];
  ssi_pkg::div_sat_t  sat_q [NQ];

  logic [RW-1:0]      r_in  [NQ];
  logic [RW-1:0]      d4_in [NQ];
  logic [NQ-1:0]      q_in  [NQ];
  ssi_pkg::div_sat_t  s_in  [NQ];
  logic [RW-1:0]      r_d   [NQ];
  logic [NQ-1:0]      q_d   [NQ];

  for (genvar k = 0; k < NQ; k++) begin : g_step
    logic          ge;
    logic [RW-1:0] diff;

    if (k == 0) begin : g_first
      assign r_in[k]  = num_i;
      assign d4_in[k] = {1'b0, den_i, 2'b00};
      assign q_in[k]  = '0;
      assign s_in[k]  = sat_i;
    end else begin : g_next
      assign r_in[k]  = r_q[k-1];
      assign d4_in[k] = d4_q[k-1];
      assign q_in[k]  = q_q[k-1];
      assign s_in[k]  = sat_q[k-1];
    end

    always_comb begin
      ge     = r_in[k] >= d4_in[k];
      diff   = ge ? r_in[k] - d4_in[k] : r_in[k];
      r_d[k] = {diff[RW-2:0], 1'b0};
      q_d[k] = {q_in[k][NQ-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= r_d[k];
        d4_q[k]  <= d4_in[k];
        q_q[k]   <= q_d[k];
        sat_q[k] <= s_in[k];
      end
    end
  end

  always_comb begin
    if (sat_q[NQ-1].hi) begin
      quo_o = FOUR;
    end else if (sat_q[NQ-1].lo) begin
      quo_o = -FOUR;
    end else begin
      quo_o = $signed({1'b0, q_q[NQ-1]}) - FOUR;
    end
  end

endmodule

`default_nettype wire

>>> src/segment_segment_intersection.sv
// ----------------------------------------------------------------------------
// segment_segment_intersection
// intersection of two fixed point 2d segments, fully pipelined
// ----------------------------------------------------------------------------
// channel | dir | payload
// cfg_i   | in  | tolerance
// seg_i   | in  | both segments' end points
// res_o   | out | kind, point_x, point_y
//
// one request per cycle while the output register is not stalled
// the two dividers produce one quotient bit per stage
// reset clears the valid bits and sets the tolerance to one lsb (2^-16)
// a stalled output register holds every stage; nothing is dropped
// ----------------------------------------------------------------------------
`default_nettype none

module segment_segment_intersection #(
  parameter int COORD_WIDTH     = ssi_pkg::COORD_WIDTH,
  parameter int COORD_FRAC_BITS = ssi_pkg::COORD_FRAC_BITS,
  parameter int PARAM_FRAC_BITS = ssi_pkg::PARAM_FRAC_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ssi_cfg_if.sink   cfg_i,
  ssi_seg_if.sink   seg_i,
  ssi_res_if.source res_o
);

  localparam int CW    = COORD_WIDTH;
  localparam int PF    = PARAM_FRAC_BITS;
  localparam int TW    = ssi_pkg::TOL_WIDTH;
  localparam int TF    = ssi_pkg::TOL_FRAC_BITS;
  localparam int DW    = CW + 1;
  localparam int PRW   = 2 * DW;
  localparam int SW    = PRW + 1;
  localparam int RW    = SW + 3;
  localparam int NQ    = PF + 3;
  localparam int QW    = PF + 4;
  localparam int SQF   = 2 * COORD_FRAC_BITS;
  localparam int SQ_UP = (SQF >= TF) ? SQF - TF : 0;
  localparam int SQ_DN = (SQF >= TF) ? 0 : TF - SQF;
  localparam int LW    = ((SW > TW + SQ_UP) ? SW : TW + SQ_UP) + 1;
  localparam int P_UP  = (PF >= TF) ? PF - TF : 0;
  localparam int P_DN  = (PF >= TF) ? 0 : TF - PF;
  localparam int PCW   = ((QW > TW + P_UP) ? QW : TW + P_UP) + 2;
  localparam int MW    = PF + 2 + DW;
  localparam logic signed [PCW-1:0] ONE  = PCW'(1) << PF;
  localparam logic signed [MW-1:0]  HALF = MW'(1) << (PF - 1);

  typedef struct packed {
    logic                 par;
    logic                 ok;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
  } side_t;

  logic en;
  logic [TW-1:0] tol_q;
  logic [LW-1:0] tsq;
  logic signed [PCW-1:0] tolp;

  assign en          = !res_o.valid || res_o.ready;
  assign seg_i.ready = en;
  assign cfg_i.ready = 1'b1;
  assign tsq  = (LW'(tol_q) >> SQ_DN) << SQ_UP;
  assign tolp = $signed((PCW'(tol_q) >> P_DN) << P_UP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TW'(1);
    end else if (cfg_i.valid) begin
      tol_q <= cfg_i.tolerance;
    end
  end

  // valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic [NQ-1:0] vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vd_q <= '0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      v8_q <= 1'b0;
      res_o.valid <= 1'b0;
    end else if (en) begin
      v1_q <= seg_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      vd_q <= {vd_q[NQ-2:0], v5_q};
      v6_q <= vd_q[NQ-1];
      v7_q <= v6_q;
      v8_q <= v7_q;
      res_o.valid <= v8_q;
    end
  end

  // stage 1: differences
  logic signed [CW-1:0] ax1_q, ay1_q;
  logic signed [DW-1:0] d1x_q, d1y_q, d2x_q, d2y_q, d3x_q, d3y_q, ex_q, ey_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= seg_i.seg_a_start_x;
      ay1_q <= seg_i.seg_a_start_y;
      d1x_q <= DW'(seg_i.seg_a_end_x) - DW'(seg_i.seg_a_start_x);
      d1y_q <= DW'(seg_i.seg_a_end_y) - DW'(seg_i.seg_a_start_y);
      d2x_q <= DW'(seg_i.seg_b_end_x) - DW'(seg_i.seg_b_start_x);
      d2y_q <= DW'(seg_i.seg_b_end_y) - DW'(seg_i.seg_b_start_y);
      d3x_q <= DW'(seg_i.seg_b_start_x) - DW'(seg_i.seg_a_start_x);
      d3y_q <= DW'(seg_i.seg_b_start_y) - DW'(seg_i.seg_a_start_y);
      ex_q  <= DW'(seg_i.seg_b_end_x) - DW'(seg_i.seg_a_start_x);
      ey_q  <= DW'(seg_i.seg_b_end_y) - DW'(seg_i.seg_a_start_y);
    end
  end

  // stage 2: products
  logic signed [PRW-1:0] p_q [12];
  logic signed [CW-1:0]  ax2_q, ay2_q;
  logic signed [DW-1:0]  d1x2_q, d1y2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]  <= d1x_q * d2y_q;
      p_q[1]  <= d1y_q * d2x_q;
      p_q[2]  <= d3x_q * d2y_q;
      p_q[3]  <= d3y_q * d2x_q;
      p_q[4]  <= d3x_q * d1y_q;
      p_q[5]  <= d3y_q * d1x_q;
      p_q[6]  <= d3x_q * d1x_q;
      p_q[7]  <= d3y_q * d1y_q;
      p_q[8]  <= ex_q * d1x_q;
      p_q[9]  <= ey_q * d1y_q;
      p_q[10] <= d1x_q * d1x_q;
      p_q[11] <= d1y_q * d1y_q;
      ax2_q   <= ax1_q;
      ay2_q   <= ay1_q;
      d1x2_q  <= d1x_q;
      d1y2_q  <= d1y_q;
    end
  end

  // stage 3: cross and dot products
  logic signed [SW-1:0] cr_q, tn_q, c2_q, dt0_q, dt1_q, len_q;
  side_t s3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cr_q  <= SW'(p_q[0]) - SW'(p_q[1]);
      tn_q  <= SW'(p_q[2]) - SW'(p_q[3]);
      c2_q  <= SW'(p_q[4]) - SW'(p_q[5]);
      dt0_q <= SW'(p_q[6]) + SW'(p_q[7]);
      dt1_q <= SW'(p_q[8]) + SW'(p_q[9]);
      len_q <= SW'(p_q[10]) + SW'(p_q[11]);
      s3_q  <= '{par: 1'b0, ok: 1'b0, ax: ax2_q, ay: ay2_q, dx: d1x2_q, dy: d1y2_q};
    end
  end

  // stage 4: parallel test and divider operand selection
  logic [LW-1:0] cr_mag, c2_mag;
  logic par, ok;
  logic signed [SW-1:0] na_sel, nb_sel, den_sel;
  logic signed [SW-1:0] na4_q, nb4_q;
  logic [SW-1:0] den4_q;
  side_t s4_q;

  always_comb begin
    cr_mag  = LW'(cr_q < 0 ? -cr_q : cr_q);
    c2_mag  = LW'(c2_q < 0 ? -c2_q : c2_q);
    par     = cr_mag <= tsq;
    ok      = (c2_mag <= tsq) && (len_q > $signed(tsq));
    na_sel  = par ? dt0_q : tn_q;
    nb_sel  = par ? dt1_q : c2_q;
    den_sel = par ? len_q : cr_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (den_sel < 0) begin
        na4_q  <= -na_sel;
        nb4_q  <= -nb_sel;
        den4_q <= SW'(-den_sel);
      end else begin
        na4_q  <= na_sel;
        nb4_q  <= nb_sel;
        den4_q <= SW'(den_sel);
      end
      s4_q <= '{par: par, ok: ok, ax: s3_q.ax, ay: s3_q.ay, dx: s3_q.dx, dy: s3_q.dy};
    end
  end

  // stage 5: saturation and offset by four
  logic signed [RW-1:0] d4, na_ext, nb_ext, na_p, nb_p;
  logic [RW-1:0] na5_q, nb5_q;
  logic [SW-1:0] den5_q;
  ssi_pkg::div_sat_t sa5_q, sb5_q;
  side_t s5_q;

  always_comb begin
    d4     = $signed({1'b0, den4_q, 2'b00});
    na_ext = RW'(na4_q);
    nb_ext = RW'(nb4_q);
    na_p   = na_ext + d4;
    nb_p   = nb_ext + d4;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      na5_q  <= na_p;
      nb5_q  <= nb_p;
      den5_q <= den4_q;
      sa5_q  <= '{hi: (na_ext - d4) >= 0, lo: na_p <= 0};
      sb5_q  <= '{hi: (nb_ext - d4) >= 0, lo: nb_p <= 0};
      s5_q   <= s4_q;
    end
  end

  // dividers
  logic signed [QW-1:0] qa, qb;

  ssi_div #(.DEN_WIDTH(SW), .PARAM_FRAC_BITS(PF)) u_div_a (
    .clk_i (clk_i), .en_i (en), .num_i (na5_q), .den_i (den5_q), .sat_i (sa5_q), .quo_o (qa)
  );

  ssi_div #(.DEN_WIDTH(SW), .PARAM_FRAC_BITS(PF)) u_div_b (
    .clk_i (clk_i), .en_i (en), .num_i (nb5_q), .den_i (den5_q), .sat_i (sb5_q), .quo_o (qb)
  );

  side_t sd_q [NQ];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= s5_q;
      for (int k = 1; k < NQ; k++) begin
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  // stage 6: ordering and range checks
  logic signed [PCW-1:0] ta, tb, t0, t1, lo, hi, mid;
  logic miss, inr;
  logic signed [PCW-1:0] lo6_q, hi6_q, mid6_q, ta6_q;
  logic miss6_q, inr6_q;
  side_t s6_q;

  always_comb begin
    ta   = PCW'(qa);
    tb   = PCW'(qb);
    t0   = (ta > tb) ? tb : ta;
    t1   = (ta > tb) ? ta : tb;
    lo   = (t0 > 0) ? t0 : '0;
    hi   = (t1 < ONE) ? t1 : ONE;
    mid  = (t0 + t1) >>> 1;
    miss = (t1 < -tolp) || (t0 > ONE + tolp);
    inr  = (ta >= -tolp) && (ta <= ONE + tolp) && (tb >= -tolp) && (tb <= ONE + tolp);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo6_q   <= lo;
      hi6_q   <= hi;
      mid6_q  <= mid;
      ta6_q   <= ta;
      miss6_q <= miss;
      inr6_q  <= inr;
      s6_q    <= sd_q[NQ-1];
    end
  end

  // stage 7: kind and clamped parameter
  logic signed [PCW-1:0] gap, gap_mag, tsel;
  logic [ssi_pkg::KIND_WIDTH-1:0] kind;
  logic [ssi_pkg::KIND_WIDTH-1:0] kind7_q;
  logic [PF:0] t7_q;
  side_t s7_q;

  always_comb begin
    gap     = lo6_q - hi6_q;
    gap_mag = (gap < 0) ? -gap : gap;
    tsel    = s6_q.par ? mid6_q : ta6_q;
    if (s6_q.par) begin
      if (!s6_q.ok || miss6_q) begin
        kind = ssi_pkg::KIND_NONE;
      end else if (gap_mag <= tolp) begin
        kind = ssi_pkg::KIND_POINT;
      end else begin
        kind = ssi_pkg::KIND_OVERLAP;
      end
    end else begin
      kind = inr6_q ? ssi_pkg::KIND_POINT : ssi_pkg::KIND_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind7_q <= kind;
      if (tsel < 0) begin
        t7_q <= '0;
      end else if (tsel > ONE) begin
        t7_q <= ONE[PF:0];
      end else begin
        t7_q <= tsel[PF:0];
      end
      s7_q <= s6_q;
    end
  end

  // stage 8: scale direction by parameter
  logic [ssi_pkg::KIND_WIDTH-1:0] kind8_q;
  logic signed [MW-1:0] mx8_q, my8_q;
  logic signed [CW-1:0] ax8_q, ay8_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind8_q <= kind7_q;
      mx8_q   <= $signed({1'b0, t7_q}) * s7_q.dx;
      my8_q   <= $signed({1'b0, t7_q}) * s7_q.dy;
      ax8_q   <= s7_q.ax;
      ay8_q   <= s7_q.ay;
    end
  end

  // output register: round and offset
  logic signed [MW-1:0] rx, ry;

  always_comb begin
    rx = (mx8_q + HALF) >>> PF;
    ry = (my8_q + HALF) >>> PF;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_o.kind <= kind8_q;
      if (kind8_q == ssi_pkg::KIND_POINT) begin
        res_o.point_x <= ax8_q + rx[CW-1:0];
        res_o.point_y <= ay8_q + ry[CW-1:0];
      end else begin
        res_o.point_x <= '0;
        res_o.point_y <= '0;
      end
    end
  end

  // checks
  a_kind_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.kind == ssi_pkg::KIND_NONE || res_o.kind == ssi_pkg::KIND_POINT ||
                     res_o.kind == ssi_pkg::KIND_OVERLAP))
    else $error("result kind out of range");

  a_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind != ssi_pkg::KIND_POINT) |->
      (res_o.point_x == '0 && res_o.point_y == '0))
    else $error("point not cleared for non-point kind");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_i.valid && seg_i.ready) |=> v1_q)
    else $error("accepted request lost at pipeline entry");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v8_q) |=> res_o.valid)
    else $error("last stage request did not reach output");

endmodule

`default_nettype wire

>>> dv/tb_segment_segment_intersection.sv
// ----------------------------------------------------------------------------
// tb_segment_segment_intersection
// streams segment pairs through the intersection block under random idling
// and checks each kind and point against a bit-exact predictor in a
// scoreboard class, across several tolerance settings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_segment_segment_intersection;

  localparam int CW = ssi_pkg::COORD_WIDTH;
  localparam int PF = ssi_pkg::PARAM_FRAC_BITS;
  localparam int KW = ssi_pkg::KIND_WIDTH;
  localparam int TW = ssi_pkg::TOL_WIDTH;
  localparam int LATENCY = PF + 12;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint P_ONE = 64'sd1 <<< PF;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct {
    logic [KW-1:0] kind;
    coord_t px, py;
  } hit_t;

  class hit_scoreboard;
    hit_t pending_hits[$];
    int errors;
    logic [TW-1:0] tol;

    function longint tol_scaled(int frac);
      if (frac >= ssi_pkg::TOL_FRAC_BITS)
        return longint'(tol) <<< (frac - ssi_pkg::TOL_FRAC_BITS);
      return longint'(tol) >> (ssi_pkg::TOL_FRAC_BITS - frac);
    endfunction

    function longint absval(longint x);
      return x < 0 ? -x : x;
    endfunction

    function longint floor_sh(longint x, int sh);
      return x >>> sh;
    endfunction

    function longint quotient(longint num, longint den);
      longint q, r, frac;
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      if (num >= 4 * den) return 4 * P_ONE;
      if (num <= -4 * den) return -4 * P_ONE;
      q = num / den;
      r = num % den;
      if (r < 0) begin
        r += den;
        q -= 1;
      end
      frac = 0;
      for (int i = 0; i < PF; i++) begin
        r = r + r;
        frac = frac + frac;
        if (r >= den) begin
          r -= den;
          frac += 1;
        end
      end
      return q * P_ONE + frac;
    endfunction

    function longint unit_clamp(longint t);
      if (t < 0) return 0;
      if (t > P_ONE) return P_ONE;
      return t;
    endfunction

    function coord_t walk(longint base, longint t, longint d);
      return coord_t'(base + floor_sh(t * d + (64'sd1 <<< (PF - 1)), PF));
    endfunction

    function void note_pair(seg_pair_t s);
      longint ax0, ay0, d1x, d1y, d2x, d2y, d3x, d3y, cr, c2, len;
      longint tsq, tp, t, t0, t1, lo, hi, tn, un, sw;
      hit_t h;
      ax0 = s.ax0;
      ay0 = s.ay0;
      d1x = longint'(s.ax1) - ax0;
      d1y = longint'(s.ay1) - ay0;
      d2x = longint'(s.bx1) - longint'(s.bx0);
      d2y = longint'(s.by1) - longint'(s.by0);
      d3x = longint'(s.bx0) - ax0;
      d3y = longint'(s.by0) - ay0;
      cr = d1x * d2y - d1y * d2x;
      tsq = tol_scaled(2 * ssi_pkg::COORD_FRAC_BITS);
      tp = tol_scaled(PF);
      t = 0;
      h.kind = ssi_pkg::KIND_NONE;
      if (absval(cr) <= tsq) begin
        c2 = d3x * d1y - d3y * d1x;
        len = d1x * d1x + d1y * d1y;
        if (absval(c2) <= tsq && len > tsq) begin
          t0 = quotient(d3x * d1x + d3y * d1y, len);
          t1 = quotient((longint'(s.bx1) - ax0) * d1x + (longint'(s.by1) - ay0) * d1y, len);
          if (t0 > t1) begin
            sw = t0;
            t0 = t1;
            t1 = sw;
          end
          if (!(t1 < -tp || t0 > P_ONE + tp)) begin
            lo = t0 > 0 ? t0 : 0;
            hi = t1 < P_ONE ? t1 : P_ONE;
            if (absval(lo - hi) <= tp) begin
              h.kind = ssi_pkg::KIND_POINT;
              t = unit_clamp(floor_sh(t0 + t1, 1));
            end else begin
              h.kind = ssi_pkg::KIND_OVERLAP;
            end
          end
        end
      end else begin
        tn = quotient(d3x * d2y - d3y * d2x, cr);
        un = quotient(d3x * d1y - d3y * d1x, cr);
        if (tn >= -tp && tn <= P_ONE + tp && un >= -tp && un <= P_ONE + tp) begin
          h.kind = ssi_pkg::KIND_POINT;
          t = unit_clamp(tn);
        end
      end
      if (h.kind == ssi_pkg::KIND_POINT) begin
        h.px = walk(ax0, t, d1x);
        h.py = walk(ay0, t, d1y);
      end else begin
        h.px = '0;
        h.py = '0;
      end
      pending_hits = {pending_hits, h};
    endfunction

    function void check_hit(logic [KW-1:0] kind, coord_t px, coord_t py);
      hit_t e;
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result kind %0d x %0d y %0d", $time, kind, px, py);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (px !== e.px) begin
        $display("%0t: point_x expected %0d actual %0d", $time, e.px, px);
        errors++;
      end
      if (py !== e.py) begin
        $display("%0t: point_y expected %0d actual %0d", $time, e.py, py);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int send_idle_pct, recv_idle_pct;
  longint cycles;
  hit_scoreboard sb;

  ssi_cfg_if cfg_if ();
  ssi_seg_if seg_if ();
  ssi_res_if res_if ();

  segment_segment_intersection dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .seg_i  (seg_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.tolerance = '0;
    seg_if.valid = 1'b0;
    {seg_if.seg_a_start_x, seg_if.seg_a_start_y, seg_if.seg_a_end_x,
     seg_if.seg_a_end_y, seg_if.seg_b_start_x, seg_if.seg_b_start_y,
     seg_if.seg_b_end_x, seg_if.seg_b_end_y} = '0;
    res_if.ready = 1'b0;
  end

  // result side: random stall, check at the rising edge
  always @(negedge clk_i) begin
    if (rst_ni) res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_hit(res_if.kind, res_if.point_x, res_if.point_y);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_tolerance(logic [TW-1:0] v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.tolerance <= v;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.tol = v;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_pair(seg_pair_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      seg_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    seg_if.valid <= 1'b1;
    seg_if.seg_a_start_x <= s.ax0;
    seg_if.seg_a_start_y <= s.ay0;
    seg_if.seg_a_end_x <= s.ax1;
    seg_if.seg_a_end_y <= s.ay1;
    seg_if.seg_b_start_x <= s.bx0;
    seg_if.seg_b_start_y <= s.by0;
    seg_if.seg_b_end_x <= s.bx1;
    seg_if.seg_b_end_y <= s.by1;
    do @(posedge clk_i); while (!seg_if.ready);
    sb.note_pair(s);
    @(negedge clk_i);
  endtask

  task automatic drain();
    seg_if.valid <= 1'b0;
    while (sb.pending_hits.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 4) @(negedge clk_i);
  endtask

  function automatic seg_pair_t mk(longint a, longint b, longint c, longint d,
                                   longint e, longint f, longint g, longint h);
    seg_pair_t s;
    s.ax0 = coord_t'(a);
    s.ay0 = coord_t'(b);
    s.ax1 = coord_t'(c);
    s.ay1 = coord_t'(d);
    s.bx0 = coord_t'(e);
    s.by0 = coord_t'(f);
    s.bx1 = coord_t'(g);
    s.by1 = coord_t'(h);
    return s;
  endfunction

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($signed($urandom_range(8191)) - 4096);
      default: return coord_t'(($signed($urandom_range(63)) - 32) <<< 12);
    endcase
  endfunction

  // well-formed geometry: collinear, touching, parallel, plus raw noise
  function automatic seg_pair_t rnd_pair();
    seg_pair_t s;
    int m;
    longint ox, oy, dx, dy, k0, k1;
    m = $urandom_range(2);
    s = mk(rnd_coord(m), rnd_coord(m), rnd_coord(m), rnd_coord(m),
           rnd_coord(m), rnd_coord(m), rnd_coord(m), rnd_coord(m));
    case ($urandom_range(5))
      0, 1: ;
      2, 3: begin
        ox = $signed($urandom_range(4095)) - 2048;
        oy = $signed($urandom_range(4095)) - 2048;
        dx = $signed($urandom_range(512)) - 256;
        dy = $signed($urandom_range(512)) - 256;
        k0 = $signed($urandom_range(12)) - 4;
        k1 = $signed($urandom_range(12)) - 4;
        s.ax0 = coord_t'(ox);
        s.ay0 = coord_t'(oy);
        s.ax1 = coord_t'(ox + 4 * dx);
        s.ay1 = coord_t'(oy + 4 * dy);
        s.bx0 = coord_t'(ox + k0 * dx);
        s.by0 = coord_t'(oy + k0 * dy);
        s.bx1 = coord_t'(ox + k1 * dx);
        s.by1 = coord_t'(oy + k1 * dy);
        if ($urandom_range(3) == 0) begin
          s.bx0 = s.bx0 + coord_t'($signed($urandom_range(2)) - 1);
        end
      end
      4: begin
        s.bx1 = s.bx0 + (s.ax1 - s.ax0);
        s.by1 = s.by0 + (s.ay1 - s.ay0);
      end
      default: begin
        s.bx0 = s.ax1;
        s.by0 = s.ay1;
      end
    endcase
    return s;
  endfunction

  localparam logic [TW-1:0] TOL_SET[4] = '{16'd0, 16'hFFFF, 16'd40, 16'd1};

  initial begin
    seg_pair_t d[$];
    sb = new();
    sb.tol = 16'd1;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // crossing, touching ends, parallel, collinear overlap/touch/disjoint
    d = {
      mk(0, 0, 4096, 4096, 0, 4096, 4096, 0),
      mk(0, 0, 4096, 0, 4096, 0, 8192, 0),
      mk(0, 0, 4096, 0, 2048, 0, 8192, 0),
      mk(0, 0, 4096, 0, 8192, 0, 12288, 0),
      mk(0, 0, 4096, 0, 0, 4096, 4096, 4096),
      mk(0, 0, 0, 0, 0, 0, 0, 0),
      mk(0, 0, 0, 0, 1, 1, 5, 5),
      mk(0, 0, 4096, 0, 8192, 4096, 8192, -4096),
      mk(-8388608, -8388608, 8388607, 8388607, -8388608, 8388607,
         8388607, -8388608),
      mk(8388607, 8388607, -8388608, -8388608, 8388607, 8388607,
         -8388608, -8388608),
      mk(-8388608, 0, 8388607, 0, 0, -8388608, 0, 8388607),
      mk(0, 0, 3, 0, 1, 1, 2, -1),
      mk(0, 0, 1, 1, 2, 2, 3, 3),
      mk(0, 0, 4096, 4096, 4096, 4096, 0, 0),
      mk(0, 0, 1, 0, 0, 5, 1, -7),
      mk(0, 0, 4096, 0, 4097, 1, 4097, -1),
      mk(0, 0, 4096, 0, -1, 0, 0, 0)
    };

    for (int ph = 0; ph < 4; ph++) begin
      write_tolerance(TOL_SET[ph]);
      if (ph == 0) foreach (d[i]) send_pair(d[i]);
      for (int n = 0; n < 480; n++) begin
        if (n < 160) begin
          send_idle_pct = 37;
          recv_idle_pct = 50;
        end else if (n < 320) begin
          send_idle_pct = 50;
          recv_idle_pct = 37;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (n == 100) begin
          seg_if.valid <= 1'b0;
          while (sb.pending_hits.size() != 0) @(negedge clk_i);
        end
        send_pair(rnd_pair());
      end
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
